[hdl/gwm_pkg.sv]
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types and constants of the glob wildcard matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

  // Pattern capacity in bytes (1 to 256).
  localparam int MAX_PATTERN = 64;

  // Pattern count holds 0..MAX_PATTERN; it also indexes the MAX_PATTERN+1 positions.
  localparam int PAT_CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int PAT_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Prefix levels needed to carry a star run across all positions.
  localparam int CLO_LVLS = $clog2(MAX_PATTERN + 1);

  // Stream widths.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam logic [7:0] GLOB_ANY_RUN = 8'h2A; // '*'
  localparam logic [7:0] GLOB_ANY_ONE = 8'h3F; // '?'

  // Position set after a restart: only position zero.
  localparam logic [MAX_PATTERN:0] ACT_RESTART = (MAX_PATTERN + 1)'(1);

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_END     = 2'd3
  } op_t;

  // Result of one NFA evaluation.
  typedef struct packed {
    logic [MAX_PATTERN:0] act_after_byte; // position set after consuming the byte
    logic                 end_hit;        // last position reachable after star closure
  } nfa_res_t;

endpackage

[hdl/gwm_nfa_step.sv]
// ----------------------------------------------------------------------------
// gwm_nfa_step
// One NFA step: star closure over all positions, byte transition, end check.
// ----------------------------------------------------------------------------
module gwm_nfa_step (
  input  logic [gwm_pkg::MAX_PATTERN:0]   act_i,
  input  logic [7:0]                      pat_byte_i [gwm_pkg::MAX_PATTERN],
  input  logic [gwm_pkg::PAT_CNT_W-1:0]   pat_cnt_i,
  input  logic [7:0]                      sym_i,
  output gwm_pkg::nfa_res_t               res_o
);
  import gwm_pkg::*;

  // Star closure as a parallel prefix: a position is reached when some
  // active position to its left connects to it through stars only.
  function automatic logic [MAX_PATTERN:0] star_closure(
    input logic [MAX_PATTERN:0]   act,
    input logic [MAX_PATTERN-1:0] prop
  );
    logic [MAX_PATTERN:0] g;
    logic [MAX_PATTERN:0] p;
    logic [MAX_PATTERN:0] g_n;
    logic [MAX_PATTERN:0] p_n;
    g = act;
    p = {prop, 1'b0}; // p[j]: position j-1 is a star
    for (int l = 0; l < CLO_LVLS; l++) begin
      for (int j = 0; j <= MAX_PATTERN; j++) begin
        if (j >= (1 << l)) begin
          g_n[j] = g[j] | (p[j] & g[j - (1 << l)]);
          p_n[j] = p[j] & p[j - (1 << l)];
        end else begin
          g_n[j] = g[j];
          p_n[j] = p[j];
        end
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

  logic [MAX_PATTERN-1:0] live;
  logic [MAX_PATTERN-1:0] star;
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN:0]   clo;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      live[i] = PAT_CNT_W'(i) < pat_cnt_i;
      star[i] = live[i] && (pat_byte_i[i] == GLOB_ANY_RUN);
      hit[i]  = live[i] && (pat_byte_i[i] != GLOB_ANY_RUN) &&
                ((pat_byte_i[i] == GLOB_ANY_ONE) || (pat_byte_i[i] == sym_i));
    end
  end

  assign clo = star_closure(act_i, star);

  // Star keeps its position, a matching byte advances one.
  assign res_o.act_after_byte = {clo[MAX_PATTERN-1:0] & hit, 1'b0} |
                                {1'b0, clo[MAX_PATTERN-1:0] & star};
  assign res_o.end_hit        = clo[pat_cnt_i];

endmodule

[hdl/glob_wildcard_matcher_unit.sv]
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_unit
// Streaming glob matcher ('*' any run, '?' any one byte) with on-chip pattern.
// ----------------------------------------------------------------------------
// An end-of-subject item passes the input register, then the result register.
// Throughput: one item per cycle unless an end item waits on a stalled result;
//   the NFA update for all positions is one combinational pass between the
//   input register and the state/result regs.
// Reset (rst_n low, synchronous): pattern empty, overflow clear, only position
//   zero active, both channels idle. Pattern bytes themselves are not cleared.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gwm_pkg::IN_TDATA_W-1:0]    in_tdata,   // [1:0] op, [9:2] data_byte, rest 0
  // Result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gwm_pkg::OUT_TDATA_W-1:0]   out_tdata   // [0] match, [1] pattern_overflow, rest 0
);
  import gwm_pkg::*;

  // ---------------- input register ----------------
  logic       s1_v_r,    s1_v_nxt;
  op_t        s1_op_r;
  logic [7:0] s1_byte_r;
  logic       s1_adv;    // item in the input register retires this cycle
  logic       in_acc;

  // ---------------- matcher state ----------------
  logic [7:0]           pat_byte_r [MAX_PATTERN];
  logic                 pat_we;
  logic [PAT_CNT_W-1:0] pat_cnt_r, pat_cnt_nxt;
  logic                 ovf_r,     ovf_nxt;
  logic [MAX_PATTERN:0] act_r,     act_nxt;

  // ---------------- result register ----------------
  logic     out_v_r,     out_v_nxt;
  logic     out_match_r, out_match_nxt;
  logic     out_ovf_r,   out_ovf_nxt;
  logic     out_free;

  nfa_res_t nfa_res;

  // Only an end-of-subject item needs the result register; other ops never stall.
  assign out_free  = !out_v_r || out_tready;
  assign s1_adv    = s1_v_r && ((s1_op_r != OP_END) || out_free);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_v_nxt  = in_acc || (s1_v_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= op_t'(in_tdata[1:0]);
      s1_byte_r <= in_tdata[9:2];
    end
  end

  gwm_nfa_step u_nfa (
    .act_i      (act_r),
    .pat_byte_i (pat_byte_r),
    .pat_cnt_i  (pat_cnt_r),
    .sym_i      (s1_byte_r),
    .res_o      (nfa_res)
  );

  // State update for the retiring item.
  always_comb begin
    pat_cnt_nxt   = pat_cnt_r;
    ovf_nxt       = ovf_r;
    act_nxt       = act_r;
    pat_we        = 1'b0;
    out_match_nxt = out_match_r;
    out_ovf_nxt   = out_ovf_r;
    out_v_nxt     = out_v_r && !out_tready;
    if (s1_adv) begin
      unique case (s1_op_r)
        OP_CLEAR: begin
          pat_cnt_nxt = '0;
          ovf_nxt     = 1'b0;
          act_nxt     = ACT_RESTART;
        end
        OP_APPEND: begin
          if (pat_cnt_r < PAT_CNT_W'(MAX_PATTERN)) begin
            pat_we      = 1'b1;
            pat_cnt_nxt = pat_cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1; // byte dropped
          end
        end
        OP_SUBJECT: begin
          act_nxt = nfa_res.act_after_byte;
        end
        OP_END: begin
          out_v_nxt     = 1'b1;
          out_match_nxt = nfa_res.end_hit && !ovf_r;
          out_ovf_nxt   = ovf_r;
          act_nxt       = ACT_RESTART;
        end
        default: begin
          act_nxt = act_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_cnt_r <= '0;
      ovf_r     <= 1'b0;
      act_r     <= ACT_RESTART;
      out_v_r   <= 1'b0;
    end else begin
      pat_cnt_r <= pat_cnt_nxt;
      ovf_r     <= ovf_nxt;
      act_r     <= act_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_match_r <= out_match_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // Pattern store: written at the fill count, every entry read in place.
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_byte_r[pat_cnt_r[PAT_IDX_W-1:0]] <= s1_byte_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, out_ovf_r, out_match_r};

endmodule

[hdl/gwm_checker.sv]
// ----------------------------------------------------------------------------
// gwm_checker
// Port-level checks of the glob wildcard matcher, bound to the top level.
// ----------------------------------------------------------------------------
module gwm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [gwm_pkg::IN_TDATA_W-1:0]    in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [gwm_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import gwm_pkg::*;

  logic end_acc;
  assign end_acc = rst_n && in_tvalid && in_tready && (in_tdata[1:0] == OP_END);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A match is never reported together with overflow.
  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0])
    else $error("match reported on overflowed pattern");

  // A new result only follows an accepted end-of-subject item.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(end_acc, 2))
    else $error("result without end-of-subject item");

  // Result channel comes out of reset idle.
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind glob_wildcard_matcher_unit gwm_checker u_gwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
